// ----- src/crs_pkg.sv -----
// Shared types and constants for the Catmull-Rom spline sampler.
// Used by the controller, the datapath, the arithmetic units and the top level.
package crs_pkg;

  // Width of the wrap-around arithmetic used for all curve sums.
  localparam int unsigned WideW = 64;
  // Width of the sample index and of the samples-per-segment register.
  localparam int unsigned CntW = 6;
  // Reset value of the samples-per-segment register.
  localparam logic [CntW-1:0] SplReset = 6'd40;
  // Scale that compares the squared derivative against the short limit.
  localparam logic [WideW-1:0] ShortScale = 64'd100000000;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_SQ2,
    OP_SQ3,
    OP_EV1,
    OP_EV2,
    OP_EV3,
    OP_DIVP_GO,
    OP_POS,
    OP_CHK1,
    OP_CHK2,
    OP_SHORT,
    OP_NORM,
    OP_SUMSQ,
    OP_ROOT_GO,
    OP_DIVT_GO,
    OP_TAN
  } crs_op_e;

  // Command group from controller to datapath.
  typedef struct packed {
    crs_op_e         op;
    logic            load_seg;
    logic            win_shift;
    logic            win_clear;
    logic            out_load;
    logic            run_end;
    logic            endpoint;
    logic [CntW-1:0] j;
    logic [CntW-1:0] s;
  } crs_cmd_t;

  // Status group from datapath to controller.
  typedef struct packed {
    logic div_done;
    logic root_done;
    logic norm_done;
    logic tan_short;
  } crs_stat_t;

endpackage

// ----- src/catmull_rom_spline_sampler_core.sv -----
// Top level of the uniform Catmull-Rom spline sampler.
// Joins crs_ctrl and crs_datapath; uses crs_pkg for the command and status types.
//
//   Channel  Handshake              Carries
//   input    in_valid_i/in_stall_o  point_x/y/z (Q16.16), final_point
//   output   out_valid_o/out_stall_i pos_x/y/z (Q16.16), tan_x/y/z (Q1.14), run_end
//   config   cfg_we_i               samples_per_segment (6 bits)
//
// A segment begins by squaring and cubing the sample count. The time of a sample
// is set by the 64-step divider bank (run once for the position and, unless the
// tangent is short, once for the tangent), the 32-step square root and the
// normalization shifter, the last two also only for a tangent that is not short.
// A stalled output holds back the next sample.
// Reset is asynchronous and active low; it clears the point window and sets
// the sample count to 40. A finished sample waits in the output register while
// the next one is computed, and the next point is taken while the last waits.
module catmull_rom_spline_sampler_core #(
  parameter int unsigned COORD_WIDTH       = 32,
  parameter int unsigned TANGENT_FRAC_BITS = 14,
  parameter int unsigned MAX_SAMPLES       = 63
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_z_i,
  input  logic                          final_point_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_WIDTH-1:0] pos_x_o,
  output logic signed [COORD_WIDTH-1:0] pos_y_o,
  output logic signed [COORD_WIDTH-1:0] pos_z_o,
  output logic signed [15:0]            tan_x_o,
  output logic signed [15:0]            tan_y_o,
  output logic signed [15:0]            tan_z_o,
  output logic                          run_end_o,
  input  logic                          cfg_we_i,
  input  logic [5:0]                    cfg_wdata_i
);

  crs_pkg::crs_cmd_t  cmd;
  crs_pkg::crs_stat_t stat;

  // Sequencer and handshakes.
  crs_ctrl #(
    .MAXS (MAX_SAMPLES)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .final_point_i (final_point_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_o         (cmd),
    .stat_i        (stat)
  );

  // Arithmetic and storage.
  crs_datapath #(
    .CW  (COORD_WIDTH),
    .TFB (TANGENT_FRAC_BITS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .point_x_i (point_x_i),
    .point_y_i (point_y_i),
    .point_z_i (point_z_i),
    .pos_x_o   (pos_x_o),
    .pos_y_o   (pos_y_o),
    .pos_z_o   (pos_z_o),
    .tan_x_o   (tan_x_o),
    .tan_y_o   (tan_y_o),
    .tan_z_o   (tan_z_o),
    .run_end_o (run_end_o)
  );

endmodule

// ----- src/crs_div.sv -----
// Restoring divider, one quotient bit per cycle, for the sampler datapath.
// Depends on crs_pkg for the operand width.
module crs_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [crs_pkg::WideW-1:0]   dividend_i,
  input  logic [crs_pkg::WideW-1:0]   divisor_i,
  output logic [crs_pkg::WideW-1:0]   quot_o,
  output logic                        done_o
);

  localparam int unsigned W = crs_pkg::WideW;
  localparam int unsigned CW = $clog2(W + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  rem_q;
  logic [W-1:0]  quo_q;
  logic [W-1:0]  den_q;
  logic [W:0]    rem_sh;
  logic [W:0]    diff;
  logic          ge;

  // One trial subtraction per cycle.
  always_comb begin
    rem_sh = {rem_q, quo_q[W-1]};
    diff   = rem_sh - {1'b0, den_q};
    ge     = rem_sh >= {1'b0, den_q};
  end

  // Control of the iteration count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[W-1:0] : rem_sh[W-1:0];
      quo_q <= {quo_q[W-2:0], ge};
    end
  end

  assign quot_o = quo_q;
  assign done_o = done_q;

endmodule

// ----- src/crs_sqrt.sv -----
// Integer square root, two radicand bits per cycle, for the tangent length.
// Depends on crs_pkg for the radicand width.
module crs_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [crs_pkg::WideW-1:0] radicand_i,
  output logic [crs_pkg::WideW/2-1:0] root_o,
  output logic                      done_o
);

  localparam int unsigned W = crs_pkg::WideW;

  logic         busy_q;
  logic         done_q;
  logic [W-1:0] x_q;
  logic [W-1:0] r_q;
  logic [W-1:0] bit_q;
  logic [W-1:0] rb;

  assign rb = r_q + bit_q;

  // Iteration control: the step with the lowest bit is the last one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (bit_q == W'(1))) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Remainder, root and trial bit.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= radicand_i;
      r_q   <= '0;
      bit_q <= W'(1) << (W - 2);
    end else if (busy_q) begin
      if (x_q >= rb) begin
        x_q <= x_q - rb;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign root_o = r_q[W/2-1:0];
  assign done_o = done_q;

endmodule

// ----- src/crs_datapath.sv -----
// Datapath of the spline sampler: point window, coefficients, cubic evaluation,
// rounding, tangent normalization and the output register. Uses crs_pkg,
// crs_div and crs_sqrt.
module crs_datapath #(
  parameter int unsigned CW  = 32,
  parameter int unsigned TFB = 14
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  crs_pkg::crs_cmd_t       cmd_i,
  output crs_pkg::crs_stat_t      stat_o,
  input  logic signed [CW-1:0]    point_x_i,
  input  logic signed [CW-1:0]    point_y_i,
  input  logic signed [CW-1:0]    point_z_i,
  output logic signed [CW-1:0]    pos_x_o,
  output logic signed [CW-1:0]    pos_y_o,
  output logic signed [CW-1:0]    pos_z_o,
  output logic signed [15:0]      tan_x_o,
  output logic signed [15:0]      tan_y_o,
  output logic signed [15:0]      tan_z_o,
  output logic                    run_end_o
);

  localparam int unsigned W = crs_pkg::WideW;

  function automatic logic [W-1:0] sx(input logic [CW-1:0] v);
    return {{(W-CW){v[CW-1]}}, v};
  endfunction

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    return v[W-1] ? (W'(0) - v) : v;
  endfunction

  logic [CW-1:0] win_q [9];
  logic [CW-1:0] pin [3];
  logic [W-1:0]  ca [3], cb [3], cc [3], cd [3];
  logic [W-1:0]  a_q [3], b_q [3], c_q [3], d_q [3];
  logic [5:0]    s_q;
  logic [11:0]   s2_q;
  logic [17:0]   s3_q;
  logic [W-1:0]  h_q [3], g_q [3], num_q [3], dn_q [3];
  logic [W-1:0]  dj [3], cs [3], hj [3], gj [3], bs2 [3], as3 [3];
  logic [W-1:0]  m_q [3];
  logic          dneg_q [3];
  logic          nneg_q [3];
  logic [28:0]   lim_q;
  logic          small_q;
  logic [33:0]   sqs_q;
  logic [57:0]   limsq_q;
  logic [61:0]   sumsq_q;
  logic [31:0]   sq16 [3];
  logic [59:0]   sq30 [3];
  logic [W-1:0]  mx;
  logic [W-1:0]  sqk;
  logic [CW-1:0] pos_q [3];
  logic [15:0]   tan_q [3];
  logic [CW-1:0] pos_sat [3];
  logic [15:0]   tan_val [3];
  logic [CW-1:0] opos_q [3];
  logic [15:0]   otan_q [3];
  logic          oend_q;
  logic [W-1:0]  jz;
  logic [W-1:0]  one;
  logic [W-1:0]  csg;
  logic [15:0]   one16;
  logic          div_go;
  logic [W-1:0]  div_num [3], div_den [3], div_quot [3];
  logic          div_done [3];
  logic [31:0]   root_len;
  logic          root_done;

  assign pin[0] = point_x_i;
  assign pin[1] = point_y_i;
  assign pin[2] = point_z_i;
  assign jz     = {{(W-6){1'b0}}, cmd_i.j};
  assign one    = W'(1) << TFB;
  assign csg    = W'(1) << (CW - 1);
  assign one16  = one[15:0];

  // Segment coefficients from the window and the new point.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ca[i] = sx(win_q[3+i]) << 1;
      cb[i] = sx(win_q[6+i]) - sx(win_q[i]);
      cc[i] = (sx(win_q[i]) << 1) - (sx(win_q[3+i]) << 2) - sx(win_q[3+i])
            + (sx(win_q[6+i]) << 2) - sx(pin[i]);
      cd[i] = (sx(win_q[3+i]) << 1) + sx(win_q[3+i]) - sx(win_q[i])
            - (sx(win_q[6+i]) << 1) - sx(win_q[6+i]) + sx(pin[i]);
    end
  end

  // Horner products for the cubic and its derivative.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dj[i]  = d_q[i] * jz;
      cs[i]  = c_q[i] * {{(W-6){1'b0}}, s_q};
      hj[i]  = h_q[i] * jz;
      gj[i]  = g_q[i] * jz;
      bs2[i] = b_q[i] * {{(W-12){1'b0}}, s2_q};
      as3[i] = a_q[i] * {{(W-18){1'b0}}, s3_q};
    end
  end

  // Tangent magnitudes: largest component and squares.
  always_comb begin
    mx = m_q[0];
    if (m_q[1] > mx) mx = m_q[1];
    if (m_q[2] > mx) mx = m_q[2];
    for (int i = 0; i < 3; i++) begin
      sq16[i] = 32'(m_q[i][15:0]) * 32'(m_q[i][15:0]);
      sq30[i] = 60'(m_q[i][29:0]) * 60'(m_q[i][29:0]);
    end
    sqk = W'(sqs_q) * crs_pkg::ShortScale;
  end

  // Rounded quotients: saturate positions and clamp tangent components.
  always_comb begin
    logic [W-1:0] sv;
    logic [W-1:0] cv;
    logic [W-1:0] tv;
    for (int i = 0; i < 3; i++) begin
      if (nneg_q[i]) begin
        sv = (div_quot[i] > csg) ? csg : (W'(0) - div_quot[i]);
      end else begin
        sv = (div_quot[i] > csg - W'(1)) ? (csg - W'(1)) : div_quot[i];
      end
      pos_sat[i] = sv[CW-1:0];
      cv = (div_quot[i] > one) ? one : div_quot[i];
      tv = dneg_q[i] ? (W'(0) - cv) : cv;
      tan_val[i] = tv[15:0];
    end
  end

  // Divider operands: rounding positions first, tangent components later.
  always_comb begin
    div_go = (cmd_i.op == crs_pkg::OP_DIVP_GO) || (cmd_i.op == crs_pkg::OP_DIVT_GO);
    for (int i = 0; i < 3; i++) begin
      if (cmd_i.op == crs_pkg::OP_DIVT_GO) begin
        div_num[i] = (m_q[i] << TFB) + {33'd0, root_len[31:1]};
        div_den[i] = {32'd0, root_len};
      end else begin
        div_num[i] = mag(num_q[i]) + {{(W-18){1'b0}}, s3_q};
        div_den[i] = {{(W-19){1'b0}}, s3_q, 1'b0};
      end
    end
  end

  for (genvar gi = 0; gi < 3; gi++) begin : g_div
    crs_div u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (div_go),
      .dividend_i (div_num[gi]),
      .divisor_i  (div_den[gi]),
      .quot_o     (div_quot[gi]),
      .done_o     (div_done[gi])
    );
  end

  crs_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.op == crs_pkg::OP_ROOT_GO),
    .radicand_i ({2'd0, sumsq_q}),
    .root_o     (root_len),
    .done_o     (root_done)
  );

  // Point window: three newest points, oldest first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) win_q[k] <= '0;
    end else if (cmd_i.win_clear) begin
      for (int k = 0; k < 9; k++) win_q[k] <= '0;
    end else if (cmd_i.win_shift) begin
      for (int k = 0; k < 6; k++) win_q[k] <= win_q[k+3];
      for (int i = 0; i < 3; i++) win_q[6+i] <= pin[i];
    end
  end

  // Working registers of one sample, stepped by the controller.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_seg) begin
      for (int i = 0; i < 3; i++) begin
        a_q[i] <= ca[i];
        b_q[i] <= cb[i];
        c_q[i] <= cc[i];
        d_q[i] <= cd[i];
      end
      s_q <= cmd_i.s;
    end
    unique case (cmd_i.op)
      crs_pkg::OP_NONE: ;
      crs_pkg::OP_SQ2: s2_q <= 12'(s_q) * 12'(s_q);
      crs_pkg::OP_SQ3: s3_q <= 18'(s2_q) * 18'(s_q);
      crs_pkg::OP_EV1: begin
        for (int i = 0; i < 3; i++) begin
          h_q[i] <= dj[i] + cs[i];
          g_q[i] <= (cs[i] << 1) + dj[i] + (dj[i] << 1);
        end
      end
      crs_pkg::OP_EV2: begin
        for (int i = 0; i < 3; i++) begin
          h_q[i]  <= hj[i] + bs2[i];
          dn_q[i] <= gj[i] + bs2[i];
        end
      end
      crs_pkg::OP_EV3: begin
        for (int i = 0; i < 3; i++) begin
          num_q[i]  <= hj[i] + as3[i];
          nneg_q[i] <= hj[i][W-1] ^ as3[i][W-1] ^ 1'b0;
        end
      end
      crs_pkg::OP_DIVP_GO: begin
        for (int i = 0; i < 3; i++) nneg_q[i] <= num_q[i][W-1];
      end
      crs_pkg::OP_POS: begin
        for (int i = 0; i < 3; i++) pos_q[i] <= pos_sat[i];
      end
      crs_pkg::OP_CHK1: begin
        for (int i = 0; i < 3; i++) begin
          m_q[i]    <= mag(dn_q[i]);
          dneg_q[i] <= dn_q[i][W-1];
        end
        lim_q <= {s2_q, 17'd0};
      end
      crs_pkg::OP_CHK2: begin
        small_q <= (mx[W-1:16] == '0);
        sqs_q   <= 34'(sq16[0]) + 34'(sq16[1]) + 34'(sq16[2]);
        limsq_q <= 58'(lim_q) * 58'(lim_q);
      end
      crs_pkg::OP_SHORT: begin
        tan_q[0] <= '0;
        tan_q[1] <= '0;
        tan_q[2] <= cmd_i.endpoint ? one16 : 16'd0;
      end
      crs_pkg::OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          if (mx[W-1:30] != '0) begin
            m_q[i] <= m_q[i] >> 1;
          end else if (!mx[29]) begin
            m_q[i] <= m_q[i] << 1;
          end
        end
      end
      crs_pkg::OP_SUMSQ: sumsq_q <= 62'(sq30[0]) + 62'(sq30[1]) + 62'(sq30[2]);
      crs_pkg::OP_ROOT_GO: ;
      crs_pkg::OP_DIVT_GO: ;
      crs_pkg::OP_TAN: begin
        for (int i = 0; i < 3; i++) tan_q[i] <= tan_val[i];
      end
      default: ;
    endcase
    // Output register holds a finished sample until it is taken.
    if (cmd_i.out_load) begin
      for (int i = 0; i < 3; i++) begin
        opos_q[i] <= pos_q[i];
        otan_q[i] <= tan_q[i];
      end
      oend_q <= cmd_i.run_end;
    end
  end

  // Status back to the controller.
  assign stat_o.div_done  = div_done[0];
  assign stat_o.root_done = root_done;
  assign stat_o.norm_done = (mx[W-1:30] == '0) && mx[29];
  assign stat_o.tan_short = small_q && (sqk <= {6'd0, limsq_q});

  assign pos_x_o   = opos_q[0];
  assign pos_y_o   = opos_q[1];
  assign pos_z_o   = opos_q[2];
  assign tan_x_o   = otan_q[0];
  assign tan_y_o   = otan_q[1];
  assign tan_z_o   = otan_q[2];
  assign run_end_o = oend_q;

endmodule

// ----- src/crs_ctrl.sv -----
// Controller of the spline sampler: handshakes, configuration register, sample
// sequencing and the datapath command stream. Uses crs_pkg.
module crs_ctrl #(
  parameter int unsigned MAXS = 63
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               final_point_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  logic               cfg_we_i,
  input  logic [5:0]         cfg_wdata_i,
  output crs_pkg::crs_cmd_t  cmd_o,
  input  crs_pkg::crs_stat_t stat_i
);

  typedef enum logic [20:0] {
    ST_IDLE      = 21'h000001,
    ST_SQ2       = 21'h000002,
    ST_SQ3       = 21'h000004,
    ST_EV1       = 21'h000008,
    ST_EV2       = 21'h000010,
    ST_EV3       = 21'h000020,
    ST_DIVP_GO   = 21'h000040,
    ST_DIVP_WAIT = 21'h000080,
    ST_POS       = 21'h000100,
    ST_CHK1      = 21'h000200,
    ST_CHK2      = 21'h000400,
    ST_CHK3      = 21'h000800,
    ST_SHORT     = 21'h001000,
    ST_NORM      = 21'h002000,
    ST_SUMSQ     = 21'h004000,
    ST_ROOT_GO   = 21'h008000,
    ST_ROOT_WAIT = 21'h010000,
    ST_DIVT_GO   = 21'h020000,
    ST_DIVT_WAIT = 21'h040000,
    ST_TAN       = 21'h080000,
    ST_OUT       = 21'h100000
  } crs_state_e;

  crs_state_e state_q, state_d;
  logic [5:0] spl_q;
  logic [5:0] j_q, j_d;
  logic       endp_q, endp_d;
  logic       fin_q;
  logic [1:0] seen_q;
  logic       oval_q;
  logic [5:0] s_eff;
  logic       accept;
  logic       out_free;
  logic       last;
  crs_pkg::crs_op_e op;

  // Effective sample count per segment.
  always_comb begin
    if (spl_q == 6'd0) begin
      s_eff = 6'd1;
    end else if (spl_q > 6'(MAXS)) begin
      s_eff = 6'(MAXS);
    end else begin
      s_eff = spl_q;
    end
  end

  assign accept   = (state_q == ST_IDLE) && in_valid_i;
  assign out_free = !oval_q || !out_stall_i;
  assign last     = endp_q || (!fin_q && (j_q == s_eff - 6'd1));

  // Next state, sample index and datapath operation.
  always_comb begin
    state_d = state_q;
    j_d     = j_q;
    endp_d  = endp_q;
    op      = crs_pkg::OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (seen_q == 2'd3)) begin
          state_d = ST_SQ2;
          j_d     = '0;
          endp_d  = 1'b0;
        end
      end
      ST_SQ2: begin
        op      = crs_pkg::OP_SQ2;
        state_d = ST_SQ3;
      end
      ST_SQ3: begin
        op      = crs_pkg::OP_SQ3;
        state_d = ST_EV1;
      end
      ST_EV1: begin
        op      = crs_pkg::OP_EV1;
        state_d = ST_EV2;
      end
      ST_EV2: begin
        op      = crs_pkg::OP_EV2;
        state_d = ST_EV3;
      end
      ST_EV3: begin
        op      = crs_pkg::OP_EV3;
        state_d = ST_DIVP_GO;
      end
      ST_DIVP_GO: begin
        op      = crs_pkg::OP_DIVP_GO;
        state_d = ST_DIVP_WAIT;
      end
      ST_DIVP_WAIT: begin
        if (stat_i.div_done) state_d = ST_POS;
      end
      ST_POS: begin
        op      = crs_pkg::OP_POS;
        state_d = ST_CHK1;
      end
      ST_CHK1: begin
        op      = crs_pkg::OP_CHK1;
        state_d = ST_CHK2;
      end
      ST_CHK2: begin
        op      = crs_pkg::OP_CHK2;
        state_d = ST_CHK3;
      end
      ST_CHK3: begin
        state_d = stat_i.tan_short ? ST_SHORT : ST_NORM;
      end
      ST_SHORT: begin
        op      = crs_pkg::OP_SHORT;
        state_d = ST_OUT;
      end
      ST_NORM: begin
        op = crs_pkg::OP_NORM;
        if (stat_i.norm_done) state_d = ST_SUMSQ;
      end
      ST_SUMSQ: begin
        op      = crs_pkg::OP_SUMSQ;
        state_d = ST_ROOT_GO;
      end
      ST_ROOT_GO: begin
        op      = crs_pkg::OP_ROOT_GO;
        state_d = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        if (stat_i.root_done) state_d = ST_DIVT_GO;
      end
      ST_DIVT_GO: begin
        op      = crs_pkg::OP_DIVT_GO;
        state_d = ST_DIVT_WAIT;
      end
      ST_DIVT_WAIT: begin
        if (stat_i.div_done) state_d = ST_TAN;
      end
      ST_TAN: begin
        op      = crs_pkg::OP_TAN;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          if (last) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_EV1;
            if (j_q == s_eff - 6'd1) begin
              j_d    = s_eff;
              endp_d = 1'b1;
            end else begin
              j_d = j_q + 6'd1;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      spl_q   <= crs_pkg::SplReset;
      j_q     <= '0;
      endp_q  <= 1'b0;
      fin_q   <= 1'b0;
      seen_q  <= '0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
      endp_q  <= endp_d;
      if (cfg_we_i) spl_q <= cfg_wdata_i;
      if (accept) begin
        fin_q <= final_point_i;
        if (final_point_i) begin
          seen_q <= '0;
        end else if (seen_q != 2'd3) begin
          seen_q <= seen_q + 2'd1;
        end
      end
      if ((state_q == ST_OUT) && out_free) begin
        oval_q <= 1'b1;
      end else if (!out_stall_i) begin
        oval_q <= 1'b0;
      end
    end
  end

  // Command group to the datapath.
  always_comb begin
    cmd_o.op        = op;
    cmd_o.load_seg  = accept;
    cmd_o.win_shift = accept && !final_point_i;
    cmd_o.win_clear = accept && final_point_i;
    cmd_o.out_load  = (state_q == ST_OUT) && out_free;
    cmd_o.run_end   = last;
    cmd_o.endpoint  = endp_q;
    cmd_o.j         = j_q;
    cmd_o.s         = s_eff;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = oval_q;

endmodule

// ----- verif/catmull_rom_spline_sampler_core_tb.sv -----
// Self-checking testbench for the Catmull-Rom spline sampler core.
// Depends on crs_pkg and catmull_rom_spline_sampler_core; predicts the samples
// by its fixed-point curve model or typed-in rows and checks the outputs.
module catmull_rom_spline_sampler_core_tb;

  localparam int unsigned IdleLimit = 20000;
  localparam logic [63:0] TanOne = 64'd1 << 14;

  // One expected sample of the curve.
  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [15:0] tx;
    logic [15:0] ty;
    logic [15:0] tz;
    logic        last;
  } curve_sample_t;

  // One row of the directed point table; zero_curve rows carry typed-in results.
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        fin;
    logic        zero_curve;
  } point_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] point_x_i = '0;
  logic [31:0] point_y_i = '0;
  logic [31:0] point_z_i = '0;
  logic        final_point_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] pos_x_o, pos_y_o, pos_z_o;
  logic [15:0] tan_x_o, tan_y_o, tan_z_o;
  logic        run_end_o;
  logic        cfg_we_i = 1'b0;
  logic [5:0]  cfg_wdata_i = '0;

  // Predictor state: three newest points, count of stored points, sample count.
  logic [31:0]              win_pts [0:8];
  int unsigned              pts_stored;
  logic [crs_pkg::CntW-1:0] seg_samples;
  logic [63:0]              seg_pts [0:11];

  curve_sample_t expected_samples [$];
  int unsigned   mismatches = 0;
  int unsigned   samples_seen = 0;
  int unsigned   points_sent = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   burst_left = 0;
  int unsigned   rx_left = 0;
  int unsigned   rx_mode = 0;

  catmull_rom_spline_sampler_core DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .point_x_i, .point_y_i, .point_z_i, .final_point_i,
    .out_valid_o, .out_stall_i,
    .pos_x_o, .pos_y_o, .pos_z_o, .tan_x_o, .tan_y_o, .tan_z_o, .run_end_o,
    .cfg_we_i, .cfg_wdata_i
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [63:0] abs64(input logic [63:0] v);
    return v[63] ? 64'd0 - v : v;
  endfunction

  // Bitwise integer square root of a 64-bit value.
  function automatic logic [63:0] root64(input logic [63:0] x);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Rounded, saturated Q16.16 position from numerator and denominator.
  function automatic logic [31:0] coord_round(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] m;
    m = (abs64(num) + den / 2) / den;
    if (num[63]) return (m > 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - m);
    return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
  endfunction

  // Normalizes the derivative; returns 0 when it is too short to carry a direction.
  function automatic bit unit_dir(input logic [63:0] d0, d1, d2, s, output logic [47:0] tv);
    logic [63:0] m [3];
    logic [63:0] dd [3];
    logic [63:0] mx, lim, sq, len, c;
    int i;
    dd[0] = d0;
    dd[1] = d1;
    dd[2] = d2;
    mx = '0;
    for (i = 0; i < 3; i++) begin
      m[i] = abs64(dd[i]);
      if (m[i] > mx) mx = m[i];
    end
    tv = '0;
    if (mx < 64'd65536) begin
      lim = 64'd131072 * s * s;
      sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      if (sq * 64'd100000000 <= lim * lim) return 1'b0;
    end
    while (mx >= (64'd1 << 30)) begin
      for (i = 0; i < 3; i++) m[i] = m[i] >> 1;
      mx = mx >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (i = 0; i < 3; i++) m[i] = m[i] << 1;
      mx = mx << 1;
    end
    len = root64(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    for (i = 0; i < 3; i++) begin
      c = (m[i] * TanOne + len / 2) / len;
      if (c > TanOne) c = TanOne;
      c = dd[i][63] ? 64'd0 - c : c;
      tv[16*(2-i) +: 16] = c[15:0];
    end
    return 1'b1;
  endfunction

  // Position and tangent of the current segment at t = j/s.
  function automatic curve_sample_t eval_sample(input logic [63:0] s, j, input bit endp);
    curve_sample_t r;
    logic [63:0] s2, s3, j2, j3, q0, q1, q2, q3, a, b, c, d, num;
    logic [63:0] dn [3];
    logic [31:0] pos [3];
    logic [47:0] tv;
    int i;
    s2 = s * s;
    s3 = s2 * s;
    j2 = j * j;
    j3 = j2 * j;
    for (i = 0; i < 3; i++) begin
      q0 = seg_pts[i];
      q1 = seg_pts[3 + i];
      q2 = seg_pts[6 + i];
      q3 = seg_pts[9 + i];
      a = 64'd2 * q1;
      b = q2 - q0;
      c = 64'd2 * q0 - 64'd5 * q1 + 64'd4 * q2 - q3;
      d = 64'd3 * q1 - q0 - 64'd3 * q2 + q3;
      num = a * s3 + b * j * s2 + c * j2 * s + d * j3;
      dn[i] = b * s2 + 64'd2 * c * j * s + 64'd3 * d * j2;
      pos[i] = coord_round(num, 64'd2 * s3);
    end
    if (!unit_dir(dn[0], dn[1], dn[2], s, tv)) tv = endp ? {32'd0, 16'(TanOne)} : '0;
    r.px = pos[0];
    r.py = pos[1];
    r.pz = pos[2];
    {r.tx, r.ty, r.tz} = tv;
    r.last = 1'b0;
    return r;
  endfunction

  // Queues an accepted point's expected samples; shifts or clears the window.
  task automatic predict_point(input logic [31:0] x, y, z, input bit fin, input bit typed);
    logic [63:0] s, j, n;
    curve_sample_t r;
    int i;
    s = (seg_samples == 0) ? 64'd1 : 64'(seg_samples);
    if (pts_stored >= 3) begin
      for (i = 0; i < 9; i++) seg_pts[i] = {{32{win_pts[i][31]}}, win_pts[i]};
      seg_pts[9] = {{32{x[31]}}, x};
      seg_pts[10] = {{32{y[31]}}, y};
      seg_pts[11] = {{32{z[31]}}, z};
      n = fin ? s + 1 : s;
      for (j = 0; j < n; j++) begin
        if (typed) begin
          // Zero points give the origin and a tangent only at the endpoint.
          r = '0;
          if (j == s) r.tz = 16'(TanOne);
        end else begin
          r = eval_sample(s, j, j == s);
        end
        r.last = (j == n - 1);
        expected_samples = {expected_samples, r};
      end
    end
    if (fin) begin
      for (i = 0; i < 9; i++) win_pts[i] = '0;
      pts_stored = 0;
    end else begin
      for (i = 0; i < 6; i++) win_pts[i] = win_pts[i + 3];
      win_pts[6] = x;
      win_pts[7] = y;
      win_pts[8] = z;
      if (pts_stored < 3) pts_stored++;
    end
  endtask

  // Sends one point in bursts with random gaps; entered and left at a falling edge.
  task automatic send_point(input logic [31:0] x, y, z, input bit fin, input bit typed);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    point_x_i <= x;
    point_y_i <= y;
    point_z_i <= z;
    final_point_i <= fin;
    do @(posedge clk_i); while (in_stall_o);
    predict_point(x, y, z, fin, typed);
    points_sent++;
    @(negedge clk_i);
  endtask

  // Waits for the block to go idle, then writes the sample count.
  task automatic write_samples(input logic [5:0] v);
    in_valid_i <= 1'b0;
    while (expected_samples.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    seg_samples = v;
  endtask

  function automatic logic [31:0] rand_coord(input int unsigned mode, input logic [31:0] prev);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 4000)) - 2000) <<< $urandom_range(0, 16);
      2: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      3: return prev + 32'($signed($urandom_range(0, 2)) - 1);
      default: return prev;
    endcase
  endfunction

  // Sends random curves until the phase has sent its share of points.
  task automatic random_curves(input int unsigned count);
    int unsigned sent, len, k, mode;
    logic [31:0] x, y, z;
    bit fin;
    sent = 0;
    x = '0;
    y = '0;
    z = '0;
    while (sent < count) begin
      // Mostly full curves; short ones end before any segment forms.
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 8);
      mode = $urandom_range(0, 4);
      for (k = 0; k < len && sent < count; k++) begin
        x = rand_coord(mode, x);
        y = rand_coord(mode, y);
        z = rand_coord(mode, z);
        if ($urandom_range(0, 9) == 0) x = $urandom;
        fin = (k == len - 1) || (sent == count - 1);
        send_point(x, y, z, fin, 1'b0);
        sent++;
      end
    end
  endtask

  // Receiver stall pattern: long stretches of one behavior at a time.
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 400);
    end
    rx_left--;
    case (rx_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= $urandom_range(0, 1);
      2: out_stall_i <= ($urandom_range(0, 7) != 0);
      default: out_stall_i <= (rx_left % 5 < 2);
    endcase
  end

  // Output checker: every accepted transaction against the oldest expectation.
  always @(posedge clk_i) begin
    curve_sample_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      samples_seen++;
      if (expected_samples.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected sample pos=(%h %h %h)", $time, pos_x_o, pos_y_o, pos_z_o);
      end else begin
        e = expected_samples.pop_front();
        if ({pos_x_o, pos_y_o, pos_z_o, tan_x_o, tan_y_o, tan_z_o, run_end_o} !== e) begin
          mismatches++;
          $display("%0t: mismatch expected pos=(%h %h %h) tan=(%h %h %h) end=%b",
                   $time, e.px, e.py, e.pz, e.tx, e.ty, e.tz, e.last);
          $display("%0t:          actual   pos=(%h %h %h) tan=(%h %h %h) end=%b",
                   $time, pos_x_o, pos_y_o, pos_z_o, tan_x_o, tan_y_o, tan_z_o, run_end_o);
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == IdleLimit) begin
      $display("%0t: no progress for %0d cycles", $time, IdleLimit);
      $display("TEST FAILED");
      $finish;
    end
  end

  point_row_t dir_rows [22];
  logic [5:0] phase_spl [7];
  int unsigned phase_items [7];

  initial begin
    int i;
    for (i = 0; i < 9; i++) win_pts[i] = '0;
    pts_stored = 0;
    seg_samples = crs_pkg::SplReset;
    dir_rows = '{
      // Zero curve ending on its fourth point.
      '{32'h0, 32'h0, 32'h0, 1'b0, 1'b1}, '{32'h0, 32'h0, 32'h0, 1'b0, 1'b1},
      '{32'h0, 32'h0, 32'h0, 1'b0, 1'b1}, '{32'h0, 32'h0, 32'h0, 1'b1, 1'b1},
      // Curves too short to give any sample.
      '{32'h1234_5678, 32'hFFFF_0000, 32'h10, 1'b0, 1'b0},
      '{32'h0001_0000, 32'h2, 32'h3, 1'b1, 1'b0},
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_AAAA, 1'b1, 1'b0},
      // Alternating extremes drive positions into saturation.
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0},
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0},
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0},
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0},
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0},
      // Nearly coincident points probe the short tangent limit.
      '{32'h0, 32'h0, 32'h0, 1'b0, 1'b0},
      '{32'h1, 32'h0, 32'h0, 1'b0, 1'b0},
      '{32'h1, 32'h0, 32'h0, 1'b0, 1'b0},
      '{32'h2, 32'h1, 32'h0, 1'b0, 1'b0},
      '{32'h2, 32'h1, 32'h0, 1'b1, 1'b0},
      // A general curve in all three axes.
      '{32'h0001_8000, 32'hFFFE_0000, 32'h0003_4000, 1'b0, 1'b0},
      '{32'h0005_0000, 32'h0002_0000, 32'hFFFF_C000, 1'b0, 1'b0},
      '{32'hFFF0_0000, 32'h0010_0000, 32'h0000_0100, 1'b0, 1'b0},
      '{32'h0020_0000, 32'hFFF8_0000, 32'h0007_0000, 1'b0, 1'b0},
      '{32'h0021_0000, 32'hFFF7_0000, 32'h0007_8000, 1'b1, 1'b0}
    };
    phase_spl = '{6'd1, 6'd63, 6'd0, 6'd2, 6'd5, 6'd3, 6'd8};
    phase_items = '{120, 8, 100, 80, 60, 60, 42};

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed points at the reset sample count.
    for (i = 0; i < 22; i++)
      send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].fin,
                 dir_rows[i].zero_curve);

    // Random curves under a series of sample counts.
    for (i = 0; i < 7; i++) begin
      write_samples(phase_spl[i]);
      random_curves(phase_items[i]);
    end

    in_valid_i <= 1'b0;
    while (expected_samples.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (expected_samples.size() != 0) begin
      mismatches++;
      $display("%0t: %0d samples never arrived", $time, expected_samples.size());
    end
    $display("Sent %0d control points over 8 sample counts and checked %0d samples.",
             points_sent, samples_seen);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- catmull_rom_spline_sampler_core.f -----
src/crs_pkg.sv
src/crs_div.sv
src/crs_sqrt.sv
src/crs_datapath.sv
src/crs_ctrl.sv
src/catmull_rom_spline_sampler_core.sv
verif/catmull_rom_spline_sampler_core_tb.sv
